FILE: rtl/core/fdmd_pkg.sv
// ============================================================================
// fdmd_pkg: shared types and constants of the frame-difference motion detector
// Register indexes, reset values, luma weights and the payload layout of the
// pixel and result streams.
// ============================================================================
package fdmd_pkg;

   // Default sizes
   localparam int STORE_PIXELS_DEF = 2097152;
   localparam int COORD_BITS_DEF   = 12;

   // Configuration port
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 23;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_FRAME_WIDTH  = 3'd0,
      REG_FRAME_HEIGHT = 3'd1,
      REG_CROP_LEFT    = 3'd2,
      REG_CROP_TOP     = 3'd3,
      REG_CROP_WIDTH   = 3'd4,
      REG_CROP_HEIGHT  = 3'd5,
      REG_PIXEL_THRESH = 3'd6,
      REG_MOTION_Q16   = 3'd7
   } csr_reg_type;

   // Register widths and reset values
   localparam int THRESH_BITS = 8;
   localparam int Q16_BITS    = 23;

   localparam int RST_FRAME_WIDTH  = 1920;
   localparam int RST_FRAME_HEIGHT = 1080;
   localparam int RST_CROP_LEFT    = 640;
   localparam int RST_CROP_TOP     = 108;
   localparam int RST_CROP_WIDTH   = 1280;
   localparam int RST_CROP_HEIGHT  = 972;
   localparam int RST_PIXEL_THRESH = 70;
   localparam int RST_MOTION_Q16   = 9830;

   // Luma weights, Q14
   localparam int LUMA_SHIFT = 14;
   localparam int LUMA_R     = 4899;
   localparam int LUMA_G     = 9617;
   localparam int LUMA_B     = 1868;
   localparam int LUMA_RND   = 8192;
   localparam int LUMA_BITS  = 22;
   localparam int GREY_BITS  = 8;

   // Motion limit: count * 100 * 2^16 against percent_q16 * area
   localparam int PCT_FULL        = 100;
   localparam int PCT_FULL_BITS   = 7;
   localparam int PCT_SCALE_SHIFT = 16;

   // Stream payloads
   localparam int CHAN_BITS    = 8;
   localparam int REQ_DATA_W   = 24;
   localparam int MOVING_BITS  = 22;
   localparam int RSP_DATA_W   = 24;

   // Result queue
   localparam int RSP_DEPTH = 4;

endpackage

FILE: rtl/core/frame_difference_motion_detector.sv
// Result path: rsp_tvalid rises after the frame's last pixel passes stages A, B and C.
// Throughput: one pixel per cycle; the frame store takes one read and one
//    write per cycle, with the write forwarded to a read of the same entry.
//    Input stalls only while four results are accepted but not yet taken.
// Reset: clears position counters, result queue and reference flag, loads
//    register defaults; store contents stay undefined, so the first frame primes.
// ============================================================================
// frame_difference_motion_detector: frame-difference motion detection
// Crops a BGR pixel stream, converts to grey, compares with the previous
// frame in a frame store and reports the moving-pixel count per frame.
// ============================================================================
module frame_difference_motion_detector #(
   parameter int STORE_PIXELS = fdmd_pkg::STORE_PIXELS_DEF,
   parameter int COORD_BITS   = fdmd_pkg::COORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // pixel stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [fdmd_pkg::REQ_DATA_W-1:0]    req_tdata,   // blue, green, red
   input  logic                               req_tuser,   // frame_start
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [fdmd_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // motion_detected,
                                                           // moving_pixels,
                                                           // priming_frame
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fdmd_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [fdmd_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import fdmd_pkg::*;

   localparam int ADDR_BITS = $clog2(STORE_PIXELS);
   localparam int CNT_BITS  = $clog2(STORE_PIXELS + 1);
   localparam int SPLIT     = (CNT_BITS + 1) / 2;
   localparam int HI_BITS   = CNT_BITS - SPLIT;
   localparam int CMP_W     = CNT_BITS + Q16_BITS;
   localparam int PTR_BITS  = $clog2(RSP_DEPTH);
   localparam int PEND_BITS = $clog2(RSP_DEPTH + 1);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [COORD_BITS-1:0]  frame_width_ff, frame_height_ff;
   logic [COORD_BITS-1:0]  crop_left_ff, crop_top_ff, crop_width_ff, crop_height_ff;
   logic [THRESH_BITS-1:0] thresh_ff;
   logic [Q16_BITS-1:0]    q16_ff;
   logic                   csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= COORD_BITS'(RST_FRAME_WIDTH);
         frame_height_ff <= COORD_BITS'(RST_FRAME_HEIGHT);
         crop_left_ff    <= COORD_BITS'(RST_CROP_LEFT);
         crop_top_ff     <= COORD_BITS'(RST_CROP_TOP);
         crop_width_ff   <= COORD_BITS'(RST_CROP_WIDTH);
         crop_height_ff  <= COORD_BITS'(RST_CROP_HEIGHT);
         thresh_ff       <= THRESH_BITS'(RST_PIXEL_THRESH);
         q16_ff          <= Q16_BITS'(RST_MOTION_Q16);
      end else if (csr_we) begin
         case (csr_reg_type'(csr_index))
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_data[COORD_BITS-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_data[COORD_BITS-1:0];
            REG_CROP_LEFT:    crop_left_ff    <= csr_data[COORD_BITS-1:0];
            REG_CROP_TOP:     crop_top_ff     <= csr_data[COORD_BITS-1:0];
            REG_CROP_WIDTH:   crop_width_ff   <= csr_data[COORD_BITS-1:0];
            REG_CROP_HEIGHT:  crop_height_ff  <= csr_data[COORD_BITS-1:0];
            REG_PIXEL_THRESH: thresh_ff       <= csr_data[THRESH_BITS-1:0];
            REG_MOTION_Q16:   q16_ff          <= csr_data[Q16_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Input stage: position, crop test and store address
   // ---------------------------------------------------------------------
   logic                  accept;
   logic                  frame_start;
   logic [CHAN_BITS-1:0]  blue, green, red;
   logic [COORD_BITS-1:0] col_ff, col_in, line_ff, line_in;
   logic [CNT_BITS-1:0]   addr_ff, addr_in;
   logic                  ref_valid_ff, ref_valid_in;
   logic [PEND_BITS-1:0]  pend_ff, pend_in;
   logic [COORD_BITS-1:0] col_c, line_c, fw_c, fh_c;
   logic [CNT_BITS-1:0]   addr_c;
   logic                  in_crop_c, keep_c, last_c;
   logic                  col_wrap_c, line_wrap_c;

   assign blue        = req_tdata[CHAN_BITS-1:0];
   assign green       = req_tdata[2*CHAN_BITS-1:CHAN_BITS];
   assign red         = req_tdata[3*CHAN_BITS-1:2*CHAN_BITS];
   assign frame_start = req_tuser;
   assign req_tready  = (pend_ff < PEND_BITS'(RSP_DEPTH));
   assign accept      = req_tvalid & req_tready;

   always_comb begin
      fw_c   = (frame_width_ff  == '0) ? COORD_BITS'(1) : frame_width_ff;
      fh_c   = (frame_height_ff == '0) ? COORD_BITS'(1) : frame_height_ff;
      col_c  = frame_start ? '0 : col_ff;
      line_c = frame_start ? '0 : line_ff;
      addr_c = frame_start ? '0 : addr_ff;

      in_crop_c = (col_c >= crop_left_ff) && ((col_c - crop_left_ff) < crop_width_ff) &&
                  (line_c >= crop_top_ff) && ((line_c - crop_top_ff) < crop_height_ff);
      keep_c    = in_crop_c && (addr_c < CNT_BITS'(STORE_PIXELS));
      last_c    = (col_c >= fw_c - 1'b1) && (line_c >= fh_c - 1'b1);

      col_wrap_c  = ({1'b0, col_c} + 1'b1) >= {1'b0, fw_c};
      line_wrap_c = ({1'b0, line_c} + 1'b1) >= {1'b0, fh_c};
   end

   // Advance position state on each accepted item
   always_comb begin
      col_in       = col_ff;
      line_in      = line_ff;
      addr_in      = addr_ff;
      ref_valid_in = ref_valid_ff;
      if (accept) begin
         if (last_c) begin
            col_in       = '0;
            line_in      = '0;
            addr_in      = '0;
            ref_valid_in = 1'b1;
         end else begin
            addr_in = addr_c + CNT_BITS'(keep_c);
            if (col_wrap_c) begin
               col_in  = '0;
               line_in = line_wrap_c ? '0 : line_c + 1'b1;
            end else begin
               col_in  = col_c + 1'b1;
               line_in = line_c;
            end
         end
      end
   end

   // Results accepted but not yet taken
   logic rsp_take;
   assign rsp_take = rsp_tvalid & rsp_tready;

   always_comb begin
      pend_in = pend_ff;
      if ((accept && last_c) && !rsp_take) begin
         pend_in = pend_ff + 1'b1;
      end else if (!(accept && last_c) && rsp_take) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         line_ff      <= '0;
         addr_ff      <= '0;
         ref_valid_ff <= 1'b0;
         pend_ff      <= '0;
      end else begin
         col_ff       <= col_in;
         line_ff      <= line_in;
         addr_ff      <= addr_in;
         ref_valid_ff <= ref_valid_in;
         pend_ff      <= pend_in;
      end
   end

   // ---------------------------------------------------------------------
   // Frame store: read at the input stage, write at the compare stage
   // ---------------------------------------------------------------------
   logic [GREY_BITS-1:0] store_mem [STORE_PIXELS];
   logic [GREY_BITS-1:0] rd_ff;
   logic [GREY_BITS-1:0] fwd_data_ff;
   logic                 fwd_ff;
   logic [ADDR_BITS-1:0] rd_addr;

   // Stage A registers
   logic                 a_valid_ff, a_keep_ff, a_clear_ff, a_last_ff, a_ref_ff;
   logic [ADDR_BITS-1:0] a_addr_ff;
   logic [CNT_BITS-1:0]  a_area_ff;
   logic [LUMA_BITS-1:0] a_pr_ff, a_pg_ff, a_pb_ff;
   logic [LUMA_BITS-1:0] a_sum;
   logic [GREY_BITS-1:0] a_grey, a_prev;
   logic [GREY_BITS:0]   a_diff;
   logic                 a_move;
   logic                 a_wr;

   assign rd_addr = addr_c[ADDR_BITS-1:0];
   assign a_wr    = a_valid_ff & a_keep_ff;

   always_ff @(posedge clock) begin
      if (a_wr) begin
         store_mem[a_addr_ff] <= a_grey;
      end
      if (accept && keep_c) begin
         rd_ff <= store_mem[rd_addr];
      end
   end

   // Forward a write that lands in the same cycle as a read of that entry
   always_ff @(posedge clock) begin
      if (accept) begin
         fwd_ff      <= a_wr && (a_addr_ff == rd_addr);
         fwd_data_ff <= a_grey;
      end
   end

   // Capture pixel into stage A, products of the luma weights
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_keep_ff  <= keep_c;
         a_clear_ff <= frame_start;
         a_last_ff  <= last_c;
         a_ref_ff   <= ref_valid_ff;
         a_addr_ff  <= rd_addr;
         a_area_ff  <= addr_c + CNT_BITS'(keep_c);
         a_pr_ff    <= LUMA_BITS'(red)   * LUMA_BITS'(LUMA_R);
         a_pg_ff    <= LUMA_BITS'(green) * LUMA_BITS'(LUMA_G);
         a_pb_ff    <= LUMA_BITS'(blue)  * LUMA_BITS'(LUMA_B);
      end
   end

   // Stage A: grey value, difference against the stored frame
   always_comb begin
      a_sum  = a_pr_ff + a_pg_ff + a_pb_ff + LUMA_BITS'(LUMA_RND);
      a_grey = a_sum[LUMA_SHIFT +: GREY_BITS];
      a_prev = fwd_ff ? fwd_data_ff : rd_ff;
      a_diff = (a_grey > a_prev) ? ({1'b0, a_grey} - {1'b0, a_prev})
                                 : ({1'b0, a_prev} - {1'b0, a_grey});
      a_move = a_keep_ff && a_ref_ff && (a_diff > {1'b0, thresh_ff});
   end

   // Moving-pixel count of the current frame
   logic [CNT_BITS-1:0] cnt_ff, cnt_in, a_count;

   always_comb begin
      a_count = (a_clear_ff ? '0 : cnt_ff) + CNT_BITS'(a_move);
      cnt_in  = cnt_ff;
      if (a_valid_ff) begin
         cnt_in = a_last_ff ? '0 : a_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result stages: limit test split into partial products
   // ---------------------------------------------------------------------
   logic                          b_valid_ff, b_prime_ff;
   logic [CNT_BITS-1:0]           b_count_ff, b_area_ff;
   logic                          c_valid_ff, c_prime_ff;
   logic [CNT_BITS-1:0]           c_count_ff;
   logic [CNT_BITS+PCT_FULL_BITS-1:0] c_lhs_ff;
   logic [Q16_BITS+SPLIT-1:0]     c_pp_lo_ff;
   logic [Q16_BITS+HI_BITS-1:0]   c_pp_hi_ff;
   logic [CMP_W-1:0]              c_lhs, c_rhs;
   logic                          c_flag;
   logic [RSP_DATA_W-1:0]         c_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff & a_last_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_prime_ff <= ~a_ref_ff;
      b_count_ff <= a_count;
      b_area_ff  <= a_area_ff;
      c_prime_ff <= b_prime_ff;
      c_count_ff <= b_count_ff;
      c_lhs_ff   <= (CNT_BITS + PCT_FULL_BITS)'(b_count_ff) *
                    (CNT_BITS + PCT_FULL_BITS)'(PCT_FULL);
      c_pp_lo_ff <= (Q16_BITS + SPLIT)'(q16_ff) *
                    (Q16_BITS + SPLIT)'(b_area_ff[SPLIT-1:0]);
      c_pp_hi_ff <= (Q16_BITS + HI_BITS)'(q16_ff) *
                    (Q16_BITS + HI_BITS)'(b_area_ff[CNT_BITS-1:SPLIT]);
   end

   always_comb begin
      c_lhs  = CMP_W'({c_lhs_ff, {PCT_SCALE_SHIFT{1'b0}}});
      c_rhs  = CMP_W'(c_pp_lo_ff) + (CMP_W'(c_pp_hi_ff) << SPLIT);
      c_flag = ~c_prime_ff && (c_lhs > c_rhs);
      c_word = {c_prime_ff, MOVING_BITS'(c_count_ff), c_flag};
   end

   // ---------------------------------------------------------------------
   // Result queue
   // ---------------------------------------------------------------------
   logic [RSP_DATA_W-1:0] rq_ff [RSP_DEPTH];
   logic [PTR_BITS:0]     wr_ptr_ff, rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (c_valid_ff) begin
         rq_ff[wr_ptr_ff[PTR_BITS-1:0]] <= c_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (c_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rsp_take) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   assign rsp_tvalid = (wr_ptr_ff != rd_ptr_ff);
   assign rsp_tdata  = rq_ff[rd_ptr_ff[PTR_BITS-1:0]];

endmodule

FILE: rtl/core/fdmd_checker.sv
// ============================================================================
// fdmd_checker: port-level checks of the motion detector
// Watches the result stream for handshake and result-consistency errors, and input ready.
// ============================================================================
module fdmd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [fdmd_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import fdmd_pkg::*;

   // Hold a stalled result item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // Drop all results on reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // Priming result carries no count and no flag
   a_prime_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_DATA_W-1] |-> rsp_tdata[RSP_DATA_W-2:0] == '0)
      else $error("priming result with motion data");

   // Motion flag needs at least one moving pixel
   a_flag_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[MOVING_BITS:1] != '0)
      else $error("motion flagged with zero moving pixels");

   // Input held off only when input was valid or queue is busy: ready low
   // means results are pending, so a result must show soon after input stops
   a_ready_pending: assert property (@(posedge clock) disable iff (reset)
      !req_tready && !req_tvalid |-> rsp_tvalid || $past(req_tvalid) ||
                                     $past(req_tvalid, 2) || $past(req_tvalid, 3))
      else $error("input blocked with no pending result");

endmodule

bind frame_difference_motion_detector fdmd_checker u_fdmd_checker (.*);

FILE: verif/frame_difference_motion_detector_test.sv
`timescale 1ns / 1ps
// ============================================================================
// frame_difference_motion_detector_test: self-checking bench for the detector
// Streams BGR pixel frames through the detector under changing crop, size,
// threshold and motion-limit settings, predicts each per-frame motion report
// from its own model of the crop, luma, frame store and limit test, and
// compares every report field by field while both stream sides idle at random.
// ============================================================================
module frame_difference_motion_detector_test;
   import fdmd_pkg::*;

   // Run length and pacing
   localparam int unsigned RANDOM_PIXELS  = 700;
   localparam int unsigned RANDOM_REPORTS = 24;
   localparam int unsigned SETTLE_CYCLES  = 8;
   // About 1.4k pixels at worst pacing, taken many times over
   localparam int unsigned CYCLE_LIMIT    = 600000;

   // Luma weights, Q14 with rounding
   localparam int unsigned GREY_R     = 4899;
   localparam int unsigned GREY_G     = 9617;
   localparam int unsigned GREY_B     = 1868;
   localparam int unsigned GREY_ROUND = 8192;
   localparam int unsigned GREY_SHIFT = 14;
   // count * 100% * 2^16 against limit * area
   localparam longint unsigned FULL_SCALE_Q16 = 64'd6553600;

   typedef struct {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       frame_start;
   } bgr_pixel_type;

   typedef struct {
      logic        motion_detected;
      logic [21:0] moving_pixels;
      logic        priming_frame;
   } motion_report_type;

   typedef struct {
      int unsigned frame_width;
      int unsigned frame_height;
      int unsigned crop_left;
      int unsigned crop_top;
      int unsigned crop_width;
      int unsigned crop_height;
      int unsigned threshold;
      int unsigned motion_q16;
   } detector_setup_type;

   // Block ports
   logic                     clock;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_W-1:0]    req_tdata  = '0;
   logic                     req_tuser  = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]    rsp_tdata;
   logic                     csr_valid  = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index  = '0;
   logic [CSR_DATA_BITS-1:0] csr_data   = '0;

   // Shadow registers, reset values
   int unsigned cfg_frame_width  = RST_FRAME_WIDTH;
   int unsigned cfg_frame_height = RST_FRAME_HEIGHT;
   int unsigned cfg_crop_left    = RST_CROP_LEFT;
   int unsigned cfg_crop_top     = RST_CROP_TOP;
   int unsigned cfg_crop_width   = RST_CROP_WIDTH;
   int unsigned cfg_crop_height  = RST_CROP_HEIGHT;
   int unsigned cfg_threshold    = RST_PIXEL_THRESH;
   int unsigned cfg_motion_q16   = RST_MOTION_Q16;

   // Predicted detector state
   byte unsigned grey_store [int unsigned];
   int unsigned  col_pos         = 0;
   int unsigned  line_pos        = 0;
   int unsigned  kept_count      = 0;
   int unsigned  moving_count    = 0;
   bit           reference_ready = 1'b0;

   motion_report_type pending_reports [$];
   int unsigned       reports_predicted = 0;
   int unsigned       pixels_sent       = 0;
   int unsigned       fail_count        = 0;
   int unsigned       cycle_count       = 0;

   // Idling controls
   int unsigned gap_pct       = 0;
   int unsigned stall_pct     = 0;
   int unsigned hold_off_left = 0;

   frame_difference_motion_detector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $error("timeout with %0d motion reports outstanding", pending_reports.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // Result side readiness: long hold-off first, else random stalls
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         hold_off_left = hold_off_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Compare each accepted report with the oldest prediction
   always @(posedge clock) begin : check_reports
      motion_report_type want;
      motion_report_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.motion_detected = rsp_tdata[0];
         got.moving_pixels   = rsp_tdata[22:1];
         got.priming_frame   = rsp_tdata[23];
         if (pending_reports.size() == 0) begin
            $error("motion report with none expected: moving_pixels %0d",
                   got.moving_pixels);
            fail_count++;
         end else begin
            want = pending_reports.pop_front();
            if (got.motion_detected !== want.motion_detected) begin
               $error("motion_detected: expected %0d, got %0d",
                      want.motion_detected, got.motion_detected);
               fail_count++;
            end
            if (got.moving_pixels !== want.moving_pixels) begin
               $error("moving_pixels: expected %0d, got %0d",
                      want.moving_pixels, got.moving_pixels);
               fail_count++;
            end
            if (got.priming_frame !== want.priming_frame) begin
               $error("priming_frame: expected %0d, got %0d",
                      want.priming_frame, got.priming_frame);
               fail_count++;
            end
         end
      end
   end

   // Advance the predicted detector by one accepted pixel
   function automatic void track_pixel(input bgr_pixel_type px);
      int unsigned       fw;
      int unsigned       fh;
      int unsigned       col;
      int unsigned       line;
      int unsigned       grey;
      int unsigned       prior;
      int unsigned       diff;
      bit                last;
      longint unsigned   lhs;
      longint unsigned   rhs;
      motion_report_type rep;
      fw = (cfg_frame_width == 0) ? 1 : cfg_frame_width;
      fh = (cfg_frame_height == 0) ? 1 : cfg_frame_height;
      if (px.frame_start) begin
         col_pos      = 0;
         line_pos     = 0;
         kept_count   = 0;
         moving_count = 0;
      end
      col  = col_pos;
      line = line_pos;

      // Inside the crop window and room left in the store
      if (col >= cfg_crop_left && col - cfg_crop_left < cfg_crop_width &&
          line >= cfg_crop_top && line - cfg_crop_top < cfg_crop_height &&
          kept_count < STORE_PIXELS_DEF) begin
         grey = (GREY_R * px.red + GREY_G * px.green + GREY_B * px.blue + GREY_ROUND)
                >> GREY_SHIFT;
         if (reference_ready) begin
            prior = grey_store.exists(kept_count) ? grey_store[kept_count] : 0;
            diff  = (grey > prior) ? grey - prior : prior - grey;
            if (diff > cfg_threshold)
               moving_count++;
         end
         grey_store[kept_count] = grey[7:0];
         kept_count++;
      end

      last = (col >= fw - 1) && (line >= fh - 1);
      if (col + 1 >= fw) begin
         col_pos  = 0;
         line_pos = (line + 1 >= fh) ? 0 : ((line + 1) & 12'hFFF);
      end else begin
         col_pos = (col + 1) & 12'hFFF;
      end

      // Frame done: emit report and rewind
      if (last) begin
         if (reference_ready) begin
            lhs = 64'(moving_count) * FULL_SCALE_Q16;
            rhs = 64'(cfg_motion_q16) * 64'(kept_count);
            rep.motion_detected = (lhs > rhs);
            rep.moving_pixels   = moving_count[21:0];
            rep.priming_frame   = 1'b0;
         end else begin
            rep.motion_detected = 1'b0;
            rep.moving_pixels   = '0;
            rep.priming_frame   = 1'b1;
         end
         pending_reports.push_back(rep);
         reports_predicted++;
         reference_ready = 1'b1;
         col_pos         = 0;
         line_pos        = 0;
         kept_count      = 0;
         moving_count    = 0;
      end
   endfunction

   function automatic bgr_pixel_type make_pixel(input logic [7:0] b, input logic [7:0] g,
                                                input logic [7:0] r, input logic start);
      bgr_pixel_type px;
      px.blue        = b;
      px.green       = g;
      px.red         = r;
      px.frame_start = start;
      return px;
   endfunction

   // Coordinate value with random junk above the 12 register bits
   function automatic logic [CSR_DATA_BITS-1:0] coord_word(input int unsigned v);
      return {11'($urandom), 12'(v)};
   endfunction

   function automatic detector_setup_type random_setup();
      detector_setup_type s;
      int unsigned        fw;
      int unsigned        fh;
      s.frame_width  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
      s.frame_height = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      fw = (s.frame_width == 0) ? 1 : s.frame_width;
      fh = (s.frame_height == 0) ? 1 : s.frame_height;
      // Mostly windows inside the frame, some hanging off or empty
      s.crop_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                  : $urandom_range(0, fw - 1);
      s.crop_top    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 11)
                                                  : $urandom_range(0, fh - 1);
      s.crop_width  = $urandom_range(1, fw + 2);
      s.crop_height = $urandom_range(1, fh + 2);
      case ($urandom_range(0, 19))
         0:       s.crop_width  = 4095;
         1:       s.crop_height = 4095;
         2:       s.crop_width  = 0;
         3:       s.crop_height = 0;
         default: ;
      endcase
      s.threshold  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 60);
      s.motion_q16 = ($urandom_range(0, 9) == 0) ? $urandom_range(6553600, 8388607)
                                                 : $urandom_range(0, 6553600);
      return s;
   endfunction

   // Offer one pixel, hold it until accepted
   task automatic send_pixel(input bgr_pixel_type px);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {px.red, px.green, px.blue};
      req_tuser  <= px.frame_start;
      do @(posedge clock); while (!req_tready);
      track_pixel(px);
      pixels_sent++;
   endtask

   task automatic send_frame(input int unsigned count, input bit mark_start);
      for (int unsigned i = 0; i < count; i++)
         send_pixel(make_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                               mark_start && i == 0));
   endtask

   // Stop offering and let every predicted report come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_FRAME_WIDTH:  cfg_frame_width  = value[11:0];
         REG_FRAME_HEIGHT: cfg_frame_height = value[11:0];
         REG_CROP_LEFT:    cfg_crop_left    = value[11:0];
         REG_CROP_TOP:     cfg_crop_top     = value[11:0];
         REG_CROP_WIDTH:   cfg_crop_width   = value[11:0];
         REG_CROP_HEIGHT:  cfg_crop_height  = value[11:0];
         REG_PIXEL_THRESH: cfg_threshold    = value[7:0];
         REG_MOTION_Q16:   cfg_motion_q16   = value;
         default:          ;
      endcase
   endtask

   // Load a full setting while the detector is idle
   task automatic configure(input detector_setup_type s);
      wait_drained();
      write_reg(REG_FRAME_WIDTH,  coord_word(s.frame_width));
      write_reg(REG_FRAME_HEIGHT, coord_word(s.frame_height));
      write_reg(REG_CROP_LEFT,    coord_word(s.crop_left));
      write_reg(REG_CROP_TOP,     coord_word(s.crop_top));
      write_reg(REG_CROP_WIDTH,   coord_word(s.crop_width));
      write_reg(REG_CROP_HEIGHT,  coord_word(s.crop_height));
      write_reg(REG_PIXEL_THRESH, {15'($urandom), 8'(s.threshold)});
      write_reg(REG_MOTION_Q16,   23'(s.motion_q16));
      csr_valid <= 1'b0;
   endtask

   // Reset settings: a few pixels left of the window, no report
   task automatic test_reset_defaults();
      send_frame(6, 1'b1);
      wait_drained();
   endtask

   // First full frame only fills the store; it sets the largest area used later
   task automatic test_priming();
      configure(detector_setup_type'{12, 8, 0, 0, 12, 8, 70, 9830});
      send_frame(96, 1'b1);
   endtask

   // Black, white, single channels and bit patterns, then the same reversed
   task automatic test_pixel_extremes();
      bgr_pixel_type shades [8];
      bgr_pixel_type px;
      shades[0] = make_pixel(8'h00, 8'h00, 8'h00, 1'b1);
      shades[1] = make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      shades[2] = make_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
      shades[3] = make_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
      shades[4] = make_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
      shades[5] = make_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
      shades[6] = make_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
      shades[7] = make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      configure(detector_setup_type'{4, 2, 0, 0, 4, 2, 254, 0});
      for (int i = 0; i < 8; i++)
         send_pixel(shades[i]);
      for (int i = 7; i >= 0; i--) begin
         px             = shades[i];
         px.frame_start = 1'b0;
         send_pixel(px);
      end
   endtask

   task automatic test_special_cases();
      // Early frame start drops the partial frame
      configure(detector_setup_type'{4, 2, 0, 0, 4, 2, 40, 3277});
      send_frame(5, 1'b1);
      send_frame(8, 1'b1);
      // Window hanging off the bottom right corner
      configure(detector_setup_type'{6, 3, 4, 1, 4095, 4095, 20, 6553600});
      send_frame(18, 1'b1);
      // Zero frame size: every pixel is a whole frame, wrapping without a start
      configure(detector_setup_type'{0, 0, 0, 0, 1, 1, 0, 0});
      send_frame(1, 1'b1);
      repeat (3) send_frame(1, 1'b0);
      // Window entirely outside: empty area never flags motion
      configure(detector_setup_type'{3, 2, 4095, 4095, 1, 1, 0, 0});
      send_frame(6, 1'b1);
   endtask

   // Wide and tall frames, cropped near their far edge to fit the primed store
   task automatic test_full_span();
      configure(detector_setup_type'{200, 1, 105, 0, 95, 4095, 255, 8388607});
      send_frame(200, 1'b1);
      configure(detector_setup_type'{1, 200, 0, 105, 4095, 95, 0, 3276800});
      send_frame(200, 1'b1);
   endtask

   // Fill the report queue against a held-off receiver, then pause the sender
   task automatic test_backpressure();
      gap_pct   = 0;
      stall_pct = 0;
      configure(detector_setup_type'{1, 1, 0, 0, 1, 1, 30, 65536});
      hold_off_left = 300;
      send_frame(1, 1'b1);
      repeat (23) send_frame(1, 1'b0);
      repeat (3) begin
         repeat (4) send_frame(1, 1'b0);
         wait_drained();
      end
   endtask

   // Random settings per phase, mostly whole frames with random content
   task automatic test_random_scenes();
      detector_setup_type setup;
      int unsigned        first_pixel;
      int unsigned        first_report;
      int unsigned        phase;
      int unsigned        frame_len;
      int unsigned        cut;
      bit                 need_start;
      first_pixel  = pixels_sent;
      first_report = reports_predicted;
      phase        = 0;
      while (pixels_sent - first_pixel < RANDOM_PIXELS ||
             reports_predicted - first_report < RANDOM_REPORTS || phase < 4) begin
         case (phase % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 81; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 81; end
            default: begin gap_pct = 15; stall_pct = 15; end
         endcase
         setup = random_setup();
         configure(setup);
         frame_len = ((setup.frame_width == 0) ? 1 : setup.frame_width) *
                     ((setup.frame_height == 0) ? 1 : setup.frame_height);
         need_start = 1'b1;
         repeat ($urandom_range(2, 8)) begin
            if (frame_len > 1 && $urandom_range(0, 99) < 12) begin
               // Broken frame: restart part way through
               cut = $urandom_range(1, frame_len - 1);
               send_frame(cut, 1'b1);
               need_start = 1'b1;
            end else begin
               send_frame(frame_len, need_start || $urandom_range(0, 1));
               need_start = 1'b0;
            end
         end
         phase++;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      gap_pct   = 15;
      stall_pct = 15;
      test_reset_defaults();
      test_priming();
      test_pixel_extremes();
      test_special_cases();
      test_full_span();
      test_backpressure();
      test_random_scenes();
      wait_drained();
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/fdmd_pkg.sv
rtl/core/frame_difference_motion_detector.sv
rtl/core/fdmd_checker.sv
verif/frame_difference_motion_detector_test.sv
